// ----- hdl/bbrc_pkg.sv -----
// Shared types and constants for the bit block rotation codec.
`timescale 1ns / 1ps

package bbrc_pkg;

    // Width of the configuration data port (widest register).
    localparam int CFG_W = 7;

    // Block size after reset.
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 7'd8;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_BLOCK_SIZE  = 1'b0,
        REG_DECODE_MODE = 1'b1
    } cfg_reg_t;

    // Input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    // Output beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_beat_t;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [CFG_W-1:0] block_size;
        logic             decode_mode;
    } cfg_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_CHUNK = 3'b001,
        ST_ROT   = 3'b010,
        ST_EMIT  = 3'b100
    } back_state_t;

    // Status of the back end, watched at the top level.
    typedef struct packed {
        logic emit_fire;
        logic emit_last;
        logic closing;
        logic block_empty;
        logic pend_empty;
    } back_stat_t;

endpackage

// ----- hdl/bbrc_front.sv -----
// Front end: accepts input beats into a two-entry queue for the back end.
`timescale 1ns / 1ps

module bbrc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bbrc_pkg::in_beat_t in_data,
    output logic               q_valid,
    input  logic               q_ready,
    output bbrc_pkg::in_beat_t q_data
);
    import bbrc_pkg::*;

    in_beat_t    mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    // Handshake on both sides of the queue.
    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/bbrc_back.sv -----
// Back end: fills blocks, rotates closed blocks and packs the bits into output bytes.
`timescale 1ns / 1ps

module bbrc_back #(
    parameter int MAX_BLOCK_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbrc_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  bbrc_pkg::in_beat_t   q_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bbrc_pkg::out_beat_t  out_data,
    output bbrc_pkg::back_stat_t stat
);
    import bbrc_pkg::*;

    localparam int BW = MAX_BLOCK_BITS;
    localparam int FW = $clog2(BW + 1);
    localparam int EW = BW + 8;
    localparam int TW = $clog2(EW);

    back_state_t   state_reg, state_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    cur_reg, cur_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          last_reg, last_next;
    logic          final_reg, final_next;
    logic [EW-1:0] emit_reg, emit_next;
    logic [TW-1:0] total_reg, total_next;
    logic [7:0]    pend_reg, pend_next;
    logic [2:0]    pcnt_reg, pcnt_next;
    logic          ovalid_reg, ovalid_next;
    out_beat_t     obeat_reg, obeat_next;

    logic [FW-1:0] size_eff;
    logic          use_head;
    logic [7:0]    w_byte;
    logic [3:0]    w_cnt;
    logic          w_last;
    logic          have;
    logic [FW-1:0] room;
    logic [3:0]    take;
    logic [7:0]    kbits;
    logic [EW-1:0] ins_wide;
    logic [BW-1:0] blk_ins;
    logic [FW-1:0] fill_ins;
    logic [3:0]    cnt_ins;
    logic          close_ins;
    logic          final_ins;
    logic [FW-1:0] pos;
    logic [BW-1:0] last_mask;
    logic          last_bit;
    logic [BW-1:0] rot_dec;
    logic [BW-1:0] rot_enc;
    logic [BW-1:0] rot;
    logic [EW-1:0] merged;
    logic [TW-1:0] total_rot;
    logic [EW-1:0] emit_shift;
    logic [TW-1:0] total_dec;
    logic          slot_free;
    logic          emit_fire;
    logic          emit_last;

    // Block size in force, clamped to 1..BW.
    always_comb
    begin
        if (cfg.block_size == '0)
        begin
            size_eff = FW'(1);
        end
        else if (int'(cfg.block_size) > BW)
        begin
            size_eff = FW'(BW);
        end
        else
        begin
            size_eff = FW'(cfg.block_size);
        end
    end

    // Working byte: the queue head when the previous byte is used up.
    assign use_head = (cnt_reg == 4'd0);
    assign w_byte   = use_head ? q_data.data_byte : cur_reg;
    assign w_cnt    = use_head ? 4'd8 : cnt_reg;
    assign w_last   = use_head ? q_data.last_byte : last_reg;
    assign have     = !use_head || q_valid;
    assign q_ready  = (state_reg == ST_CHUNK) && use_head;

    // Take as many bits as fit before the block closes, at least one.
    always_comb
    begin
        if (fill_reg < size_eff)
        begin
            room = size_eff - fill_reg;
        end
        else
        begin
            room = FW'(1);
        end
        if (int'(room) < int'(w_cnt))
        begin
            take = 4'(room);
        end
        else
        begin
            take = w_cnt;
        end
    end

    // Append the chunk below the bits already in the block.
    assign kbits     = w_byte & ~(8'hFF >> take);
    assign ins_wide  = {kbits, {BW{1'b0}}} >> fill_reg;
    assign blk_ins   = blk_reg | ins_wide[EW-1:8];
    assign fill_ins  = fill_reg + FW'(take);
    assign cnt_ins   = w_cnt - take;
    assign final_ins = (cnt_ins == 4'd0) && w_last;
    assign close_ins = (fill_ins >= size_eff) || final_ins;

    // Rotate the closed block; its bits sit at the top of the register.
    assign pos       = FW'(BW) - fill_reg;
    assign last_mask = BW'(1) << pos;
    assign last_bit  = |(blk_reg & last_mask);
    assign rot_dec   = (blk_reg << 1) | (blk_reg[BW-1] ? last_mask : '0);
    assign rot_enc   = ((blk_reg & ~last_mask) >> 1) | (BW'(last_bit) << (BW - 1));
    assign rot       = cfg.decode_mode ? rot_dec : rot_enc;

    // Join the pending bits and the rotated block, first bit highest.
    assign merged    = {pend_reg, {BW{1'b0}}} | ({rot, 8'b0} >> pcnt_reg);
    assign total_rot = TW'(pcnt_reg) + TW'(fill_reg);

    assign emit_shift = emit_reg << 8;
    assign total_dec  = total_reg - TW'(8);
    assign slot_free  = !ovalid_reg || out_ready;

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        blk_next    = blk_reg;
        fill_next   = fill_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        final_next  = final_reg;
        emit_next   = emit_reg;
        total_next  = total_reg;
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        ovalid_next = ovalid_reg;
        obeat_next  = obeat_reg;
        emit_fire   = 1'b0;
        emit_last   = 1'b0;

        unique case (state_reg)
            ST_CHUNK:
            begin
                if (have)
                begin
                    blk_next  = blk_ins;
                    fill_next = fill_ins;
                    cur_next  = w_byte << take;
                    cnt_next  = cnt_ins;
                    last_next = w_last;
                    if (close_ins)
                    begin
                        final_next = final_ins;
                        state_next = ST_ROT;
                    end
                end
            end
            ST_ROT:
            begin
                blk_next  = '0;
                fill_next = '0;
                if (total_rot >= TW'(8))
                begin
                    emit_next  = merged;
                    total_next = total_rot;
                    state_next = ST_EMIT;
                end
                else
                begin
                    pend_next  = final_reg ? 8'd0 : merged[EW-1 -: 8];
                    pcnt_next  = final_reg ? 3'd0 : total_rot[2:0];
                    state_next = ST_CHUNK;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    emit_fire  = 1'b1;
                    emit_last  = final_reg && (total_dec == '0);
                    emit_next  = emit_shift;
                    total_next = total_dec;
                    if (total_dec < TW'(8))
                    begin
                        pend_next  = final_reg ? 8'd0 : emit_shift[EW-1 -: 8];
                        pcnt_next  = final_reg ? 3'd0 : total_dec[2:0];
                        state_next = ST_CHUNK;
                    end
                end
            end
            default:
            begin
                state_next = ST_CHUNK;
            end
        endcase

        // Output register: load a new beat or drop the one taken.
        if (emit_fire)
        begin
            ovalid_next         = 1'b1;
            obeat_next.out_byte = emit_reg[EW-1 -: 8];
            obeat_next.out_last = emit_last;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CHUNK;
            blk_reg    <= '0;
            fill_reg   <= '0;
            cnt_reg    <= 4'd0;
            last_reg   <= 1'b0;
            final_reg  <= 1'b0;
            total_reg  <= '0;
            pend_reg   <= 8'd0;
            pcnt_reg   <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            blk_reg    <= blk_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            final_reg  <= final_next;
            total_reg  <= total_next;
            pend_reg   <= pend_next;
            pcnt_reg   <= pcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        emit_reg  <= emit_next;
        obeat_reg <= obeat_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = obeat_reg;

    assign stat.emit_fire   = emit_fire;
    assign stat.emit_last   = emit_last;
    assign stat.closing     = (state_reg == ST_ROT);
    assign stat.block_empty = (fill_reg == '0);
    assign stat.pend_empty  = (pcnt_reg == 3'd0);

endmodule

// ----- hdl/bit_block_rotation_codec.sv -----
// Top level of the bit block rotation codec: configuration registers, front and back end.
//
// Usage: bytes enter on in_valid/in_ready/in_data, most significant bit first; a
// beat with last_byte set ends the stream and flushes the open partial block.
// Coded bytes leave on out_valid/out_ready/out_data, and the final byte of a
// stream carries out_last. Each block of block_size bits (1..MAX_BLOCK_BITS) is
// rotated right by one bit (decode_mode 0) or left by one bit (decode_mode 1).
// Registers are to be written by the user through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this.
// Sequencing: for each byte the back end appends the bits that fit in the open
// block (ST_CHUNK); a block end adds a rotation step (ST_ROT), an emit step for
// each output byte formed (ST_EMIT), and another chunk step when bits of the
// byte remain after it. The back end sequencer paces the input; a two-entry
// input queue keeps taking beats while it works.
// Reset: block_size returns to 8, decode_mode to encode, and all open block and
// pending bits are cleared. No clearing pass is needed.
// Stall: when out_ready is low the output beat holds, the back end waits, and the
// input queue fills and then drops in_ready.
`timescale 1ns / 1ps

module bit_block_rotation_codec #(
    parameter int MAX_BLOCK_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bbrc_pkg::in_beat_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bbrc_pkg::out_beat_t           out_data,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [bbrc_pkg::CFG_W-1:0]    cfg_data
);
    import bbrc_pkg::*;

    logic [CFG_W-1:0] block_size_reg;
    logic             decode_mode_reg;
    cfg_t             cfg;
    logic             q_valid;
    logic             q_ready;
    in_beat_t         q_data;
    back_stat_t       back_stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg  <= BLOCK_SIZE_RESET;
            decode_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BLOCK_SIZE:  block_size_reg  <= cfg_data;
                REG_DECODE_MODE: decode_mode_reg <= cfg_data[0];
            endcase
        end
    end

    assign cfg.block_size  = block_size_reg;
    assign cfg.decode_mode = decode_mode_reg;

    // Input queue.
    bbrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    // Block assembly, rotation and byte packing.
    bbrc_back #(
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .stat      (back_stat)
    );

`ifndef SYNTHESIS
    // The back end never overwrites an output beat that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.emit_fire |-> (!out_valid || out_ready))
        else $error("output beat overwritten while stalled");

    // A block only closes when it holds at least one bit.
    a_close_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.closing |-> !back_stat.block_empty)
        else $error("empty block closed");

    // After the final byte of a stream no pending bits remain.
    a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.emit_fire && back_stat.emit_last |=> back_stat.pend_empty)
        else $error("pending bits left after end of stream");
`endif

endmodule

// ----- verif/bit_block_rotation_codec_test.sv -----
// Self-checking testbench for the bit block rotation codec.
`timescale 1ns / 1ps

module bit_block_rotation_codec_test;
    import bbrc_pkg::*;

    localparam int MAX_BITS      = 64;
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 260;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC
    } ready_style_e;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_beat_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_beat_t            out_data;
    logic                 cfg_we;
    logic [0:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Shadow of the registers and of the bits held inside the codec.
    logic [CFG_W-1:0]     model_block_size;
    logic                 model_decode;
    logic [63:0]          open_block;
    int unsigned          open_fill;
    logic [7:0]           pack_byte;
    int unsigned          pack_count;

    // Coded bytes still owed by the codec, oldest first.
    out_beat_t            coded_bytes_due[$];
    out_beat_t            step_bytes[$];

    int unsigned          mismatches = 0;
    int unsigned          bytes_sent = 0;
    int unsigned          bytes_checked = 0;
    int unsigned          streams_closed = 0;
    int unsigned          settings_used = 0;
    int unsigned          burst_left = 0;
    int unsigned          quiet_cycles = 0;
    logic                 sender_steady = 1'b0;
    logic                 hold_off_request = 1'b0;

    bit_block_rotation_codec #(
        .MAX_BLOCK_BITS (MAX_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Block size actually used: zero acts as one, oversize is clamped.
    function automatic int unsigned active_block_bits();
        int unsigned s;
        s = model_block_size;
        if (s < 1)
            s = 1;
        if (s > MAX_BITS)
            s = MAX_BITS;
        return s;
    endfunction

    // Append one coded bit; a full byte becomes an expected beat.
    task automatic push_coded_bit(input logic b_val);
        out_beat_t full_beat;
        pack_byte = {pack_byte[6:0], b_val};
        pack_count++;
        if (pack_count >= 8)
        begin
            full_beat.out_byte = pack_byte;
            full_beat.out_last = 1'b0;
            step_bytes.insert(step_bytes.size(), full_beat);
            pack_byte  = '0;
            pack_count = 0;
        end
    endtask

    // Rotate the open block by one bit in the current direction and emit it.
    task automatic close_open_block();
        int unsigned n;
        logic [63:0] mask;
        logic [63:0] v;
        if (open_fill == 0)
            return;
        n    = (open_fill > 64) ? 64 : open_fill;
        mask = (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
        v    = open_block & mask;
        if (model_decode)
            v = ((v << 1) & mask) | ((v >> (n - 1)) & 64'd1);
        else
            v = (v >> 1) | ((v & 64'd1) << (n - 1));
        for (int i = n; i > 0; i--)
            push_coded_bit(v[i - 1]);
        open_block = '0;
        open_fill  = 0;
    endtask

    // Work out the coded bytes that one accepted input beat causes.
    task automatic predict_coded_bytes(input in_beat_t beat);
        step_bytes.delete();
        for (int k = 7; k >= 0; k--)
        begin
            open_block = {open_block[62:0], beat.data_byte[k]};
            open_fill++;
            if (open_fill >= active_block_bits())
                close_open_block();
        end
        // The end of a stream flushes the partial block and marks the final byte.
        if (beat.last_byte)
        begin
            close_open_block();
            pack_byte  = '0;
            pack_count = 0;
            if (step_bytes.size() > 0)
                step_bytes[step_bytes.size() - 1].out_last = 1'b1;
        end
        foreach (step_bytes[j])
            coded_bytes_due.insert(coded_bytes_due.size(), step_bytes[j]);
    endtask

    // Write one register; only called while the codec is idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BLOCK_SIZE:  model_block_size = val;
            REG_DECODE_MODE: model_decode     = val[0];
            default: ;
        endcase
        settings_used++;
    endtask

    // Offer one input beat, with random gaps between bursts, and wait for it to be taken.
    task automatic send_byte(input logic [7:0] value, input logic ends_stream);
        in_beat_t beat;
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = sender_steady ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        beat.data_byte = value;
        beat.last_byte = ends_stream;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_coded_bytes(beat);
        burst_left--;
        bytes_sent++;
        if (ends_stream)
            streams_closed++;
    endtask

    // Stop sending, let every owed byte arrive, then give the back end time to settle.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (coded_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly legal sizes, with zero and oversize values mixed in.
    function automatic logic [CFG_W-1:0] pick_block_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(65, 127));
            2:       return CFG_W'(MAX_BITS);
            3:       return CFG_W'($urandom_range(1, 3));
            default: return CFG_W'($urandom_range(1, MAX_BITS));
        endcase
    endfunction

    task automatic test_default_config();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        wait_until_idle();
    endtask

    task automatic test_block_size_extremes();
        // One-bit blocks pass through unchanged.
        write_reg(REG_BLOCK_SIZE, CFG_W'(1));
        send_byte(8'h5A, 1'b1);
        wait_until_idle();
        // Widest block, rotated left, closes exactly on the final byte.
        write_reg(REG_BLOCK_SIZE, CFG_W'(MAX_BITS));
        write_reg(REG_DECODE_MODE, CFG_W'(1));
        for (int i = 0; i < 8; i++)
            send_byte(8'h80 | 8'(i * 17), i == 7);
        wait_until_idle();
        // Zero acts as one.
        write_reg(REG_BLOCK_SIZE, '0);
        write_reg(REG_DECODE_MODE, '0);
        send_byte(8'hC3, 1'b1);
        wait_until_idle();
        // Largest register value is clamped; the stream ends inside a block.
        write_reg(REG_BLOCK_SIZE, {CFG_W{1'b1}});
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h3C, 1'b1);
        wait_until_idle();
    endtask

    task automatic test_partial_block_flush();
        write_reg(REG_BLOCK_SIZE, CFG_W'(5));
        write_reg(REG_DECODE_MODE, CFG_W'(1));
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b1);
        wait_until_idle();
    endtask

    task automatic test_mid_block_changes();
        // Leave a block open, then shrink the size under it.
        write_reg(REG_BLOCK_SIZE, CFG_W'(20));
        write_reg(REG_DECODE_MODE, '0);
        send_byte(8'h12, 1'b0);
        wait_until_idle();
        write_reg(REG_BLOCK_SIZE, CFG_W'(3));
        send_byte(8'h34, 1'b0);
        wait_until_idle();
        // Flip the direction while a bit is still open.
        write_reg(REG_DECODE_MODE, CFG_W'(1));
        send_byte(8'h56, 1'b1);
        wait_until_idle();
    endtask

    task automatic test_random_streams();
        int unsigned random_sent;
        int unsigned len;
        logic closes;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            // New setting; the mode write carries random upper data bits.
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_BLOCK_SIZE, pick_block_size());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_DECODE_MODE, CFG_W'($urandom_range(0, 127)));
            sender_steady = ($urandom_range(0, 3) == 0);
            len    = $urandom_range(1, 24);
            // Some streams stop without an end mark and carry an open block on.
            closes = ($urandom_range(0, 7) != 0);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)), closes && (i == len - 1));
            random_sent += len;
            wait_until_idle();
        end
    endtask

    task automatic test_output_hold_off();
        write_reg(REG_BLOCK_SIZE, pick_block_size());
        sender_steady    = 1'b1;
        hold_off_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom_range(0, 255)), i == 39);
        wait_until_idle();
        sender_steady = 1'b0;
    endtask

    // Receiver: changes stall style every so often and honors a long hold-off.
    initial
    begin : receiver
        ready_style_e style;
        int unsigned  style_left;
        int unsigned  hold_left;
        style      = READY_ALWAYS;
        style_left = 0;
        hold_left  = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_CYCLES;
            end
            if (style_left == 0)
            begin
                style      = ready_style_e'($urandom_range(0, 2));
                style_left = $urandom_range(20, 120);
            end
            style_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (style)
                    READY_ALWAYS:   out_ready <= 1'b1;
                    READY_RANDOM:   out_ready <= ($urandom_range(0, 9) >= 4);
                    default:        out_ready <= ((style_left % 5) > 1);
                endcase
            end
        end
    end

    // Compare each output beat with the oldest owed byte.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (coded_bytes_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, actual byte %02h last %0b",
                         $time, out_data.out_byte, out_data.out_last);
            end
            else
            begin
                want = coded_bytes_due.pop_front();
                bytes_checked++;
                if (out_data.out_byte !== want.out_byte)
                begin
                    mismatches++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.out_byte, out_data.out_byte);
                end
                if (out_data.out_last !== want.out_last)
                begin
                    mismatches++;
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.out_last, out_data.out_last);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_BLOCK_SIZE;
        cfg_data  <= '0;
        model_block_size = BLOCK_SIZE_RESET;
        model_decode     = 1'b0;
        open_block       = '0;
        open_fill        = 0;
        pack_byte        = '0;
        pack_count       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_config();
        test_block_size_extremes();
        test_partial_block_flush();
        test_mid_block_changes();
        test_random_streams();
        test_output_hold_off();

        wait_until_idle();
        if (coded_bytes_due.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d coded bytes never arrived", $time, coded_bytes_due.size());
        end
        $display("Sent %0d bytes in %0d ended streams over %0d register writes; checked %0d bytes.",
                 bytes_sent, streams_closed, settings_used, bytes_checked);
        $display("Covered sizes zero to 127, both directions, mid-block changes and a long hold-off.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bbrc_pkg.sv
hdl/bbrc_front.sv
hdl/bbrc_back.sv
hdl/bit_block_rotation_codec.sv
verif/bit_block_rotation_codec_test.sv
